// ----- sv/mrs_pkg.sv -----
package mrs_pkg;

    // fixed field widths
    localparam int ACTION_W   = 3;
    localparam int POT_W      = 10;
    localparam int DELAY_W    = 32;
    localparam int ANGLE_W    = 8;
    localparam int SPEED_W    = 9;
    localparam int PWM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int ANGLE_LIMIT    = 90;
    localparam int SERVO_OFFSET   = 90;
    localparam int ADC_FULL_SCALE = 1023;

    // quotient bits per divider cycle, 8-bit dividend
    localparam int DIV_BITS_PER_STEP = 2;
    localparam int DIV_STEPS         = 8 / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    // register reset values
    localparam logic [7:0]  TURN_ANGLE_RST    = 8'd45;
    localparam logic [7:0]  FORWARD_ANGLE_RST = 8'd0;
    localparam logic [6:0]  ANGLE_STEP_RST    = 7'd5;
    localparam logic [7:0]  SPEED_STEP_RST    = 8'd5;
    localparam logic [15:0] ANGLE_DLY_RST     = 16'd20;
    localparam logic [15:0] SPEED_DLY_RST     = 16'd20;
    localparam logic [7:0]  ROT_DIV_RST       = 8'd2;
    localparam logic [7:0]  SPEED_LIMIT_RST   = 8'd255;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_FWD    = 3'd1,
        ACT_BACK   = 3'd2,
        ACT_LEFT   = 3'd3,
        ACT_RIGHT  = 3'd4,
        ACT_STOP   = 3'd5,
        ACT_ARM    = 3'd6,
        ACT_CANCEL = 3'd7
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TURN_ANGLE    = 3'd0,
        CFG_FORWARD_ANGLE = 3'd1,
        CFG_ANGLE_STEP    = 3'd2,
        CFG_SPEED_STEP    = 3'd3,
        CFG_ANGLE_DLY     = 3'd4,
        CFG_SPEED_DLY     = 3'd5,
        CFG_ROT_DIV       = 3'd6,
        CFG_SPEED_LIMIT   = 3'd7
    } t_cfg_reg;

    // controller to datapath, at most one bit set at a time by construction
    typedef struct packed {
        logic capture;
        logic full_fix;
        logic div_step;
        logic seq_step;
    } t_cmd;

endpackage

// ----- sv/mrs_ctrl.sv -----
module mrs_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output mrs_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_FULL = 4'b0010,
        C_DIV  = 4'b0100,
        C_SEQ  = 4'b1000
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic [mrs_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic r_valid, n_valid;
    logic w_out_free;

    assign w_out_free = !r_valid || !i_stall;

    assign o_cmd.capture  = (r_state == C_IDLE) && i_valid;
    assign o_cmd.full_fix = (r_state == C_FULL);
    assign o_cmd.div_step = (r_state == C_DIV);
    assign o_cmd.seq_step = (r_state == C_SEQ) && w_out_free;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        case (r_state)
            C_IDLE: begin
                if (i_valid) n_state = C_FULL;
            end
            C_FULL: begin
                n_div_cnt = '0;
                n_state   = C_DIV;
            end
            C_DIV: begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == mrs_pkg::DIV_CNT_W'(mrs_pkg::DIV_STEPS - 1)) n_state = C_SEQ;
            end
            C_SEQ: begin
                if (w_out_free) n_state = C_IDLE;
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.seq_step) n_valid = 1'b1;
        else if (r_valid && !i_stall) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= C_IDLE;
            r_div_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
            r_valid   <= n_valid;
        end
    end

    assign o_stall = (r_state != C_IDLE);
    assign o_valid = r_valid;

endmodule

// ----- sv/mrs_datapath.sv -----
module mrs_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mrs_pkg::t_cmd                     i_cmd,
    input  logic                              i_cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [mrs_pkg::ACTION_W-1:0]      i_action,
    input  logic [mrs_pkg::POT_W-1:0]         i_pot_value,
    input  logic [mrs_pkg::DELAY_W-1:0]       i_stop_delay,
    output logic [mrs_pkg::PWM_W-1:0]         o_right_fwd_pwm,
    output logic [mrs_pkg::PWM_W-1:0]         o_right_rev_pwm,
    output logic [mrs_pkg::PWM_W-1:0]         o_left_fwd_pwm,
    output logic [mrs_pkg::PWM_W-1:0]         o_left_rev_pwm,
    output logic [mrs_pkg::ANGLE_W-1:0]       o_servo_position,
    output logic                              o_ramp_busy
);

    typedef enum logic [4:0] {
        SQ_WAIT      = 5'b00001,
        SQ_TURN      = 5'b00010,
        SQ_TURN_DLY  = 5'b00100,
        SQ_SPEED     = 5'b01000,
        SQ_SPEED_DLY = 5'b10000
    } t_seq_state;

    typedef enum logic [2:0] {
        DS_IDLE    = 3'b001,
        DS_PENDING = 3'b010,
        DS_RUNNING = 3'b100
    } t_ds_phase;

    // ---- helpers
    function automatic logic signed [10:0] f_step_toward(input logic signed [10:0] cur,
                                                         input logic signed [10:0] tgt,
                                                         input logic signed [10:0] stp);
        logic signed [10:0] nxt;
        logic signed [10:0] dif;
        logic signed [10:0] mg;
        nxt = (cur < tgt) ? cur + stp : cur - stp;
        dif = tgt - nxt;
        mg  = (dif < 0) ? -dif : dif;
        return (mg < stp) ? tgt : nxt;
    endfunction

    function automatic logic signed [8:0] f_sat9(input logic signed [10:0] v);
        logic signed [8:0] res;
        if (v > 11'sd255)        res = 9'sd255;
        else if (v < -11'sd256)  res = 9'h100;
        else                     res = v[8:0];
        return res;
    endfunction

    function automatic logic [8:0] f_mag9(input logic signed [8:0] v);
        return v[8] ? (~v + 9'd1) : v;
    endfunction

    function automatic logic [7:0] f_mag8(input logic signed [7:0] v);
        return v[7] ? (~v + 8'd1) : v;
    endfunction

    // two restoring divide iterations; returns {rem, quot}
    function automatic logic [15:0] f_div2(input logic [7:0] rem, input logic [7:0] quo,
                                           input logic [7:0] dvs);
        logic [8:0] r9;
        logic [7:0] rr;
        logic [7:0] qq;
        rr = rem;
        qq = quo;
        for (int k = 0; k < mrs_pkg::DIV_BITS_PER_STEP; k++) begin
            r9 = {rr, qq[7]};
            qq = {qq[6:0], 1'b0};
            if (r9 >= {1'b0, dvs}) begin
                r9    = r9 - {1'b0, dvs};
                qq[0] = 1'b1;
            end
            rr = r9[7:0];
        end
        return {rr, qq};
    endfunction

    // ---- configuration
    logic signed [7:0] r_turn_angle, r_forward_angle;
    logic [6:0]        r_angle_step;
    logic [7:0]        r_speed_step, r_rot_div, r_speed_limit;
    logic [15:0]       r_angle_dly, r_speed_dly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_angle    <= mrs_pkg::TURN_ANGLE_RST;
            r_forward_angle <= mrs_pkg::FORWARD_ANGLE_RST;
            r_angle_step    <= mrs_pkg::ANGLE_STEP_RST;
            r_speed_step    <= mrs_pkg::SPEED_STEP_RST;
            r_angle_dly     <= mrs_pkg::ANGLE_DLY_RST;
            r_speed_dly     <= mrs_pkg::SPEED_DLY_RST;
            r_rot_div       <= mrs_pkg::ROT_DIV_RST;
            r_speed_limit   <= mrs_pkg::SPEED_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrs_pkg::CFG_TURN_ANGLE:    r_turn_angle    <= i_cfg_data[7:0];
                mrs_pkg::CFG_FORWARD_ANGLE: r_forward_angle <= i_cfg_data[7:0];
                mrs_pkg::CFG_ANGLE_STEP:    r_angle_step    <= i_cfg_data[6:0];
                mrs_pkg::CFG_SPEED_STEP:    r_speed_step    <= i_cfg_data[7:0];
                mrs_pkg::CFG_ANGLE_DLY:     r_angle_dly     <= i_cfg_data[15:0];
                mrs_pkg::CFG_SPEED_DLY:     r_speed_dly     <= i_cfg_data[15:0];
                mrs_pkg::CFG_ROT_DIV:       r_rot_div       <= i_cfg_data[7:0];
                mrs_pkg::CFG_SPEED_LIMIT:   r_speed_limit   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---- sequencer state
    t_seq_state        r_seq_state, n_seq_state;
    logic              r_cmd_pending, n_cmd_pending;
    logic [2:0]        r_cmd_code, n_cmd_code;
    logic signed [7:0] r_target_angle, n_target_angle;
    logic signed [8:0] r_target_left, n_target_left;
    logic signed [8:0] r_target_right, n_target_right;
    logic signed [7:0] r_ramp_angle, n_ramp_angle;
    logic signed [8:0] r_ramp_left, n_ramp_left;
    logic signed [8:0] r_ramp_right, n_ramp_right;
    logic signed [7:0] r_applied_angle, n_applied_angle;
    logic signed [8:0] r_applied_left, n_applied_left;
    logic signed [8:0] r_applied_right, n_applied_right;
    logic              r_wheel_aligned, n_wheel_aligned;
    t_ds_phase         r_dstop_phase, n_dstop_phase;
    logic              r_dstop_armed, n_dstop_armed;
    logic [31:0]       r_dstop_delay, n_dstop_delay;
    logic [31:0]       r_dstop_count, n_dstop_count;
    logic [15:0]       r_wait, n_wait;

    // ---- work registers of one pass
    logic [17:0] r_prod, n_prod;
    logic [7:0]  r_qest, n_qest;
    logic [7:0]  r_full, n_full;
    logic [7:0]  r_div_q, n_div_q;
    logic [7:0]  r_div_rem, n_div_rem;

    // ---- command latch and deferred stop, applied at capture
    logic        l_pending;
    logic [2:0]  l_code;
    logic        l_armed;
    t_ds_phase   l_phase;
    logic [31:0] l_dreg;
    logic [31:0] l_count;

    always_comb begin
        l_pending = r_cmd_pending;
        l_code    = r_cmd_code;
        l_armed   = r_dstop_armed;
        l_phase   = r_dstop_phase;
        l_dreg    = r_dstop_delay;
        l_count   = r_dstop_count;
        if (i_action inside {[mrs_pkg::ACT_FWD:mrs_pkg::ACT_STOP]}) begin
            l_pending = 1'b1;
            l_code    = i_action;
        end else if (i_action == mrs_pkg::ACT_ARM && i_stop_delay != '0) begin
            l_dreg  = i_stop_delay;
            l_armed = 1'b1;
        end else if (i_action inside {mrs_pkg::ACT_ARM, mrs_pkg::ACT_CANCEL}) begin
            l_phase = DS_IDLE;
            l_armed = 1'b0;
        end
        case (l_phase)
            DS_IDLE: begin
                if (l_armed) begin
                    l_armed = 1'b0;
                    l_phase = DS_PENDING;
                end
            end
            DS_PENDING: begin
                if (r_wheel_aligned) begin
                    l_count = l_dreg;
                    l_phase = DS_RUNNING;
                end
            end
            DS_RUNNING: begin
                if (l_count != '0) l_count = l_count - 32'd1;
                if (l_count == '0) begin
                    l_pending = 1'b1;
                    l_code    = mrs_pkg::ACT_STOP;
                    l_phase   = DS_IDLE;
                end
            end
            default: l_phase = DS_IDLE;
        endcase
    end

    // ---- pot scaling: pot*255/1023 via *1025>>20 (1023*1025 = 2^20-1), then one fix-up
    logic [17:0] w_prod;
    logic [27:0] w_scaled;
    logic [17:0] w_qm;
    logic [17:0] w_rem;
    logic [7:0]  w_full;

    assign w_prod   = {i_pot_value, 8'd0} - {8'd0, i_pot_value};
    assign w_scaled = {w_prod, 10'd0} + {10'd0, w_prod};
    assign w_qm     = {r_qest, 10'd0} - {10'd0, r_qest};
    assign w_rem    = r_prod - w_qm;
    assign w_full   = r_qest + 8'((w_rem >= 18'(mrs_pkg::ADC_FULL_SCALE)) ? 1 : 0);

    logic [7:0]  w_divisor;
    logic [15:0] w_div_res;
    assign w_divisor = (r_rot_div == '0) ? 8'd1 : r_rot_div;
    assign w_div_res = f_div2(r_div_rem, r_div_q, w_divisor);

    // ---- ramp steps
    logic signed [10:0] w_astep, w_sstep, w_angle_next;
    logic signed [8:0]  w_left_next, w_right_next;
    logic signed [8:0]  w_full_p, w_full_n, w_rot_p, w_rot_n;
    logic               w_stopped;
    logic [15:0]        w_dly;
    t_seq_state         w_dly_next;
    logic [8:0]         w_mag_l, w_mag_r;
    logic [8:0]         w_mag_nl, w_mag_nr;

    assign w_astep = {4'd0, (r_angle_step == '0) ? 7'd1 : r_angle_step};
    assign w_sstep = {3'd0, (r_speed_step == '0) ? 8'd1 : r_speed_step};

    assign w_angle_next = f_step_toward({{3{r_ramp_angle[7]}}, r_ramp_angle},
                                        {{3{r_target_angle[7]}}, r_target_angle}, w_astep);
    assign w_left_next  = f_sat9(f_step_toward({{2{r_ramp_left[8]}}, r_ramp_left},
                                               {{2{r_target_left[8]}}, r_target_left},
                                               w_sstep));
    assign w_right_next = f_sat9(f_step_toward({{2{r_ramp_right[8]}}, r_ramp_right},
                                               {{2{r_target_right[8]}}, r_target_right},
                                               w_sstep));
    assign w_mag_l = f_mag9(w_left_next);
    assign w_mag_r = f_mag9(w_right_next);

    assign w_full_p  = {1'b0, r_full};
    assign w_full_n  = -w_full_p;
    assign w_rot_p   = {1'b0, r_div_q};
    assign w_rot_n   = -w_rot_p;
    assign w_stopped = (r_applied_left == '0) && (r_applied_right == '0);

    assign w_dly      = (r_seq_state == SQ_TURN_DLY) ? r_angle_dly : r_speed_dly;
    assign w_dly_next = (r_seq_state == SQ_TURN_DLY) ? SQ_TURN : SQ_SPEED;

    always_comb begin
        n_seq_state     = r_seq_state;
        n_cmd_pending   = r_cmd_pending;
        n_cmd_code      = r_cmd_code;
        n_target_angle  = r_target_angle;
        n_target_left   = r_target_left;
        n_target_right  = r_target_right;
        n_ramp_angle    = r_ramp_angle;
        n_ramp_left     = r_ramp_left;
        n_ramp_right    = r_ramp_right;
        n_applied_angle = r_applied_angle;
        n_applied_left  = r_applied_left;
        n_applied_right = r_applied_right;
        n_wheel_aligned = r_wheel_aligned;
        n_dstop_phase   = r_dstop_phase;
        n_dstop_armed   = r_dstop_armed;
        n_dstop_delay   = r_dstop_delay;
        n_dstop_count   = r_dstop_count;
        n_wait          = r_wait;
        n_prod          = r_prod;
        n_qest          = r_qest;
        n_full          = r_full;
        n_div_q         = r_div_q;
        n_div_rem       = r_div_rem;

        if (i_cmd.capture) begin
            n_cmd_pending = l_pending;
            n_cmd_code    = l_code;
            n_dstop_phase = l_phase;
            n_dstop_armed = l_armed;
            n_dstop_delay = l_dreg;
            n_dstop_count = l_count;
            n_prod        = w_prod;
            n_qest        = w_scaled[27:20];
        end else if (i_cmd.full_fix) begin
            n_full    = w_full;
            n_div_q   = w_full;
            n_div_rem = '0;
        end else if (i_cmd.div_step) begin
            n_div_rem = w_div_res[15:8];
            n_div_q   = w_div_res[7:0];
        end else if (i_cmd.seq_step) begin
            case (r_seq_state)
                SQ_WAIT: begin
                    if (r_cmd_pending) begin
                        n_cmd_pending = 1'b0;
                        case (r_cmd_code)
                            mrs_pkg::ACT_FWD, mrs_pkg::ACT_BACK: begin
                                if (w_stopped) begin
                                    n_target_angle = r_forward_angle;
                                    n_target_left  = (r_cmd_code == mrs_pkg::ACT_FWD) ?
                                                     w_full_p : w_full_n;
                                    n_target_right = n_target_left;
                                end
                            end
                            mrs_pkg::ACT_LEFT, mrs_pkg::ACT_RIGHT: begin
                                if (w_stopped) begin
                                    n_target_angle = r_turn_angle;
                                    n_target_left  = (r_cmd_code == mrs_pkg::ACT_LEFT) ?
                                                     w_rot_n : w_rot_p;
                                    n_target_right = (r_cmd_code == mrs_pkg::ACT_LEFT) ?
                                                     w_rot_p : w_rot_n;
                                end
                            end
                            mrs_pkg::ACT_STOP: begin
                                // hold the wheel where it is, ramp speeds to zero
                                n_target_angle = r_ramp_angle;
                                n_target_left  = '0;
                                n_target_right = '0;
                            end
                            default: ;
                        endcase
                        n_wheel_aligned = 1'b0;
                        n_seq_state     = SQ_TURN;
                    end
                end
                SQ_TURN: begin
                    if (r_ramp_angle != r_target_angle) begin
                        n_ramp_angle = w_angle_next[7:0];
                        if (f_mag8(w_angle_next[7:0]) <= 8'(mrs_pkg::ANGLE_LIMIT))
                            n_applied_angle = w_angle_next[7:0];
                        n_seq_state = SQ_TURN_DLY;
                    end else begin
                        n_wheel_aligned = 1'b1;
                        n_seq_state     = SQ_SPEED;
                    end
                end
                SQ_SPEED: begin
                    // both wheels step whenever either is off target
                    if (r_ramp_left != r_target_left || r_ramp_right != r_target_right) begin
                        n_ramp_left  = w_left_next;
                        n_ramp_right = w_right_next;
                        if (w_mag_l <= {1'b0, r_speed_limit}) n_applied_left  = w_left_next;
                        if (w_mag_r <= {1'b0, r_speed_limit}) n_applied_right = w_right_next;
                        n_seq_state = SQ_SPEED_DLY;
                    end else begin
                        n_seq_state = SQ_WAIT;
                    end
                end
                SQ_TURN_DLY, SQ_SPEED_DLY: begin
                    // a pending command aborts the ramp
                    if (r_cmd_pending) begin
                        n_wait      = '0;
                        n_seq_state = SQ_WAIT;
                    end else if (r_wait >= w_dly) begin
                        n_wait      = '0;
                        n_seq_state = w_dly_next;
                    end else begin
                        n_wait = r_wait + 16'd1;
                    end
                end
                default: n_seq_state = SQ_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_state     <= SQ_WAIT;
            r_cmd_pending   <= 1'b0;
            r_cmd_code      <= '0;
            r_target_angle  <= '0;
            r_target_left   <= '0;
            r_target_right  <= '0;
            r_ramp_angle    <= '0;
            r_ramp_left     <= '0;
            r_ramp_right    <= '0;
            r_applied_angle <= mrs_pkg::FORWARD_ANGLE_RST;
            r_applied_left  <= '0;
            r_applied_right <= '0;
            r_wheel_aligned <= 1'b0;
            r_dstop_phase   <= DS_IDLE;
            r_dstop_armed   <= 1'b0;
            r_dstop_delay   <= '0;
            r_dstop_count   <= '0;
            r_wait          <= '0;
        end else begin
            r_seq_state     <= n_seq_state;
            r_cmd_pending   <= n_cmd_pending;
            r_cmd_code      <= n_cmd_code;
            r_target_angle  <= n_target_angle;
            r_target_left   <= n_target_left;
            r_target_right  <= n_target_right;
            r_ramp_angle    <= n_ramp_angle;
            r_ramp_left     <= n_ramp_left;
            r_ramp_right    <= n_ramp_right;
            r_applied_angle <= n_applied_angle;
            r_applied_left  <= n_applied_left;
            r_applied_right <= n_applied_right;
            r_wheel_aligned <= n_wheel_aligned;
            r_dstop_phase   <= n_dstop_phase;
            r_dstop_armed   <= n_dstop_armed;
            r_dstop_delay   <= n_dstop_delay;
            r_dstop_count   <= n_dstop_count;
            r_wait          <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= n_prod;
        r_qest    <= n_qest;
        r_full    <= n_full;
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
    end

    // ---- output word, formed from the post-step state
    logic [7:0] r_out_rf, r_out_rr, r_out_lf, r_out_lr, r_out_servo;
    logic       r_out_busy;

    assign w_mag_nl = f_mag9(n_applied_left);
    assign w_mag_nr = f_mag9(n_applied_right);

    always_ff @(posedge i_clk) begin
        if (i_cmd.seq_step) begin
            r_out_rf    <= (n_applied_right > 0) ? n_applied_right[7:0] : 8'd0;
            r_out_rr    <= (n_applied_right > 0) ? 8'd0 : w_mag_nr[7:0];
            r_out_lf    <= (n_applied_left > 0) ? n_applied_left[7:0] : 8'd0;
            r_out_lr    <= (n_applied_left > 0) ? 8'd0 : w_mag_nl[7:0];
            r_out_servo <= $unsigned(n_applied_angle) + 8'(mrs_pkg::SERVO_OFFSET);
            r_out_busy  <= (n_seq_state != SQ_WAIT);
        end
    end

    assign o_right_fwd_pwm  = r_out_rf;
    assign o_right_rev_pwm  = r_out_rr;
    assign o_left_fwd_pwm   = r_out_lf;
    assign o_left_rev_pwm   = r_out_lr;
    assign o_servo_position = r_out_servo;
    assign o_ramp_busy      = r_out_busy;

endmodule

// ----- sv/motor_ramp_sequencer_core.sv -----
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// input    | i_valid / o_stall  | i_action, i_pot_value, i_stop_delay
// output   | o_valid / i_stall  | o_right/left_fwd/rev_pwm, o_servo_position, o_ramp_busy
// config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// One word passes through capture, pot scale fix-up, the divider steps (2 quotient
// bits each, rotate divisor), and the sequencer step that loads the output register.
// The result word is registered at the sequencer step; a new word is taken only after that step.
// Reset is synchronous, active low; config returns to its default values.
// A stalled output holds the sequencer step until the waiting word is taken.
module motor_ramp_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [mrs_pkg::ACTION_W-1:0]    i_action,
    input  logic [mrs_pkg::POT_W-1:0]       i_pot_value,
    input  logic [mrs_pkg::DELAY_W-1:0]     i_stop_delay,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mrs_pkg::PWM_W-1:0]       o_right_fwd_pwm,
    output logic [mrs_pkg::PWM_W-1:0]       o_right_rev_pwm,
    output logic [mrs_pkg::PWM_W-1:0]       o_left_fwd_pwm,
    output logic [mrs_pkg::PWM_W-1:0]       o_left_rev_pwm,
    output logic [mrs_pkg::ANGLE_W-1:0]     o_servo_position,
    output logic                            o_ramp_busy,
    input  logic                            i_cfg_we,
    input  logic [mrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mrs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    mrs_pkg::t_cmd w_cmd;

    mrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    mrs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_pot_value      (i_pot_value),
        .i_stop_delay     (i_stop_delay),
        .o_right_fwd_pwm  (o_right_fwd_pwm),
        .o_right_rev_pwm  (o_right_rev_pwm),
        .o_left_fwd_pwm   (o_left_fwd_pwm),
        .o_left_rev_pwm   (o_left_rev_pwm),
        .o_servo_position (o_servo_position),
        .o_ramp_busy      (o_ramp_busy)
    );

`ifndef SYNTHESIS
    // accepted word keeps the input side closed while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after acceptance");

    // step never overwrites a word still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.seq_step |-> (!o_valid || !i_stall))
        else $error("output word overwritten while stalled");

    // a new result only comes from a sequencer step
    a_valid_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.seq_step))
        else $error("output valid without sequencer step");
`endif

endmodule

// ----- sim/mrs_drive_checker.sv -----
module mrs_drive_checker
    import mrs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [POT_W-1:0]      i_pot_value,
    input  logic [DELAY_W-1:0]    i_stop_delay,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [PWM_W-1:0]      i_right_fwd_pwm,
    input  logic [PWM_W-1:0]      i_right_rev_pwm,
    input  logic [PWM_W-1:0]      i_left_fwd_pwm,
    input  logic [PWM_W-1:0]      i_left_rev_pwm,
    input  logic [ANGLE_W-1:0]    i_servo_position,
    input  logic                  i_ramp_busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PWM_FULL = 255;

    typedef enum logic [2:0] {
        SQ_WAIT,
        SQ_TURN,
        SQ_TURN_DLY,
        SQ_SPEED,
        SQ_SPEED_DLY
    } t_seq;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_PENDING,
        DS_RUNNING
    } t_dstop;

    typedef struct packed {
        logic [PWM_W-1:0]   rf;
        logic [PWM_W-1:0]   rr;
        logic [PWM_W-1:0]   lf;
        logic [PWM_W-1:0]   lr;
        logic [ANGLE_W-1:0] servo;
        logic               busy;
    } t_drive_word;

    // register copies
    logic signed [7:0] cfg_turn, cfg_fwd;
    logic [6:0]        cfg_astep;
    logic [7:0]        cfg_sstep, cfg_div, cfg_lim;
    logic [15:0]       cfg_adly, cfg_sdly;

    // sequencer state
    t_seq                      seq;
    logic                      pend;
    t_action                   pend_code;
    logic signed [ANGLE_W-1:0] tgt_ang, ramp_ang, app_ang;
    logic signed [SPEED_W-1:0] tgt_l, tgt_r, ramp_l, ramp_r, app_l, app_r;
    logic                      aligned;
    t_dstop                    ds;
    logic                      ds_armed;
    logic [DELAY_W-1:0]        ds_delay, ds_count;
    logic [15:0]               wcnt;

    t_drive_word expected_drive[$];
    t_drive_word want, seen;
    int          fails = 0;
    int          pending_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;

    function automatic int mag_of(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int step_to(int cur, int tgt, int stp);
        int n;
        n = (cur < tgt) ? cur + stp : cur - stp;
        if (mag_of(tgt - n) < stp) n = tgt;
        return n;
    endfunction

    function automatic int clamp9(int v);
        if (v > 255) return 255;
        if (v < -256) return -256;
        return v;
    endfunction

    function void reset_model();
        cfg_turn  = TURN_ANGLE_RST;
        cfg_fwd   = FORWARD_ANGLE_RST;
        cfg_astep = ANGLE_STEP_RST;
        cfg_sstep = SPEED_STEP_RST;
        cfg_adly  = ANGLE_DLY_RST;
        cfg_sdly  = SPEED_DLY_RST;
        cfg_div   = ROT_DIV_RST;
        cfg_lim   = SPEED_LIMIT_RST;
        seq       = SQ_WAIT;
        pend      = 1'b0;
        pend_code = ACT_TICK;
        tgt_ang   = '0;
        ramp_ang  = '0;
        app_ang   = FORWARD_ANGLE_RST;
        tgt_l     = '0;
        tgt_r     = '0;
        ramp_l    = '0;
        ramp_r    = '0;
        app_l     = '0;
        app_r     = '0;
        aligned   = 1'b0;
        ds        = DS_IDLE;
        ds_armed  = 1'b0;
        ds_delay  = '0;
        ds_count  = '0;
        wcnt      = '0;
    endfunction

    function void write_setting(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TURN_ANGLE:    cfg_turn  = data[7:0];
            CFG_FORWARD_ANGLE: cfg_fwd   = data[7:0];
            CFG_ANGLE_STEP:    cfg_astep = data[6:0];
            CFG_SPEED_STEP:    cfg_sstep = data[7:0];
            CFG_ANGLE_DLY:     cfg_adly  = data;
            CFG_SPEED_DLY:     cfg_sdly  = data;
            CFG_ROT_DIV:       cfg_div   = data[7:0];
            CFG_SPEED_LIMIT:   cfg_lim   = data[7:0];
            default: ;
        endcase
    endfunction

    function t_drive_word advance_ramp_tick(t_action act, logic [POT_W-1:0] pot,
                                            logic [DELAY_W-1:0] sdly);
        int          astep, sstep, full, dv, rot, nl, nr, na, m, sv;
        logic        stopped;
        t_drive_word w;
        astep = (cfg_astep == 0) ? 1 : int'(cfg_astep);
        sstep = (cfg_sstep == 0) ? 1 : int'(cfg_sstep);

        // latch the word's action
        if (act >= ACT_FWD && act <= ACT_STOP) begin
            pend = 1'b1;
            pend_code = act;
        end else if (act == ACT_ARM && sdly != 0) begin
            ds_delay = sdly;
            ds_armed = 1'b1;
        end else if (act == ACT_ARM || act == ACT_CANCEL) begin
            ds = DS_IDLE;
            ds_armed = 1'b0;
        end

        // deferred stop
        case (ds)
            DS_IDLE: begin
                if (ds_armed) begin
                    ds_armed = 1'b0;
                    ds = DS_PENDING;
                end
            end
            DS_PENDING: begin
                if (aligned) begin
                    ds_count = ds_delay;
                    ds = DS_RUNNING;
                end
            end
            DS_RUNNING: begin
                if (ds_count > 0) ds_count = ds_count - 32'd1;
                if (ds_count == 0) begin
                    pend = 1'b1;
                    pend_code = ACT_STOP;
                    ds = DS_IDLE;
                end
            end
            default: ds = DS_IDLE;
        endcase

        case (seq)
            SQ_WAIT: begin
                if (pend) begin
                    pend = 1'b0;
                    full = int'(pot) * PWM_FULL / ADC_FULL_SCALE;
                    dv = (cfg_div == 0) ? 1 : int'(cfg_div);
                    rot = full / dv;
                    stopped = (app_l == 0) && (app_r == 0);
                    case (pend_code)
                        ACT_FWD, ACT_BACK: begin
                            if (stopped) begin
                                tgt_ang = cfg_fwd;
                                tgt_l = (pend_code == ACT_FWD) ? SPEED_W'(full)
                                                               : SPEED_W'(-full);
                                tgt_r = tgt_l;
                            end
                        end
                        ACT_LEFT, ACT_RIGHT: begin
                            if (stopped) begin
                                tgt_ang = cfg_turn;
                                tgt_l = (pend_code == ACT_LEFT) ? SPEED_W'(-rot)
                                                                : SPEED_W'(rot);
                                tgt_r = -tgt_l;
                            end
                        end
                        ACT_STOP: begin
                            tgt_ang = ramp_ang;
                            tgt_l = '0;
                            tgt_r = '0;
                        end
                        default: ;
                    endcase
                    aligned = 1'b0;
                    seq = SQ_TURN;
                end
            end
            SQ_TURN: begin
                if (ramp_ang != tgt_ang) begin
                    na = step_to(ramp_ang, tgt_ang, astep);
                    ramp_ang = ANGLE_W'(na);
                    if (mag_of(na) <= ANGLE_LIMIT) app_ang = ANGLE_W'(na);
                    seq = SQ_TURN_DLY;
                end else begin
                    aligned = 1'b1;
                    seq = SQ_SPEED;
                end
            end
            SQ_TURN_DLY: begin
                if (pend) begin
                    wcnt = '0;
                    seq = SQ_WAIT;
                end else if (wcnt >= cfg_adly) begin
                    wcnt = '0;
                    seq = SQ_TURN;
                end else begin
                    wcnt = wcnt + 16'd1;
                end
            end
            SQ_SPEED: begin
                if (ramp_l != tgt_l || ramp_r != tgt_r) begin
                    // both wheels step, even one already on target
                    nl = clamp9(step_to(ramp_l, tgt_l, sstep));
                    nr = clamp9(step_to(ramp_r, tgt_r, sstep));
                    ramp_l = SPEED_W'(nl);
                    ramp_r = SPEED_W'(nr);
                    if (mag_of(nl) <= int'(cfg_lim)) app_l = SPEED_W'(nl);
                    if (mag_of(nr) <= int'(cfg_lim)) app_r = SPEED_W'(nr);
                    seq = SQ_SPEED_DLY;
                end else begin
                    seq = SQ_WAIT;
                end
            end
            SQ_SPEED_DLY: begin
                if (pend) begin
                    wcnt = '0;
                    seq = SQ_WAIT;
                end else if (wcnt >= cfg_sdly) begin
                    wcnt = '0;
                    seq = SQ_SPEED;
                end else begin
                    wcnt = wcnt + 16'd1;
                end
            end
            default: seq = SQ_WAIT;
        endcase

        m = mag_of(app_r);
        w.rf = (app_r > 0) ? app_r[7:0] : '0;
        w.rr = (app_r > 0) ? '0 : m[7:0];
        m = mag_of(app_l);
        w.lf = (app_l > 0) ? app_l[7:0] : '0;
        w.lr = (app_l > 0) ? '0 : m[7:0];
        sv = int'(app_ang) + SERVO_OFFSET;
        w.servo = sv[7:0];
        w.busy = (seq != SQ_WAIT);
        return w;
    endfunction

    function void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_drive.delete();
        end else begin
            if (i_cfg_we) write_setting(t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (i_in_valid && !i_in_stall)
                expected_drive.push_back(advance_ramp_tick(t_action'(i_action),
                                                           i_pot_value, i_stop_delay));
            if (i_out_valid && !i_out_stall) begin
                seen = {i_right_fwd_pwm, i_right_rev_pwm, i_left_fwd_pwm,
                        i_left_rev_pwm, i_servo_position, i_ramp_busy};
                if (expected_drive.size() == 0) begin
                    $error("drive word with nothing expected");
                    fails++;
                end else begin
                    want = expected_drive.pop_front();
                    check_field("right_fwd_pwm", want.rf, seen.rf);
                    check_field("right_rev_pwm", want.rr, seen.rr);
                    check_field("left_fwd_pwm", want.lf, seen.lf);
                    check_field("left_rev_pwm", want.lr, seen.lr);
                    check_field("servo_position", want.servo, seen.servo);
                    check_field("ramp_busy", want.busy, seen.busy);
                end
            end
        end
        pending_cnt = expected_drive.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mrs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_PHASES = 10;
    localparam int WORDS_PER_PHASE = 48;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [ACTION_W-1:0]   i_action;
    logic [POT_W-1:0]      i_pot_value;
    logic [DELAY_W-1:0]    i_stop_delay;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [PWM_W-1:0]      o_right_fwd_pwm;
    logic [PWM_W-1:0]      o_right_rev_pwm;
    logic [PWM_W-1:0]      o_left_fwd_pwm;
    logic [PWM_W-1:0]      o_left_rev_pwm;
    logic [ANGLE_W-1:0]    o_servo_position;
    logic                  o_ramp_busy;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int idle_mode;
    int send_idle_pct;
    int cycles;

    always #2 i_clk = ~i_clk;

    motor_ramp_sequencer_core u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_pot_value      (i_pot_value),
        .i_stop_delay     (i_stop_delay),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_right_fwd_pwm  (o_right_fwd_pwm),
        .o_right_rev_pwm  (o_right_rev_pwm),
        .o_left_fwd_pwm   (o_left_fwd_pwm),
        .o_left_rev_pwm   (o_left_rev_pwm),
        .o_servo_position (o_servo_position),
        .o_ramp_busy      (o_ramp_busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    mrs_drive_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_action         (i_action),
        .i_pot_value      (i_pot_value),
        .i_stop_delay     (i_stop_delay),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_right_fwd_pwm  (o_right_fwd_pwm),
        .i_right_rev_pwm  (o_right_rev_pwm),
        .i_left_fwd_pwm   (o_left_fwd_pwm),
        .i_left_rev_pwm   (o_left_rev_pwm),
        .i_servo_position (o_servo_position),
        .i_ramp_busy      (o_ramp_busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (idle_mode)
                0: i_stall <= ($urandom_range(0, 99) < 47);
                1: i_stall <= ($urandom_range(0, 99) < 28);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // leaves valid high on return; the next call drops it if it idles
    task automatic send_word(input t_action act, input logic [POT_W-1:0] pot,
                             input logic [DELAY_W-1:0] sd);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= act;
        i_pot_value  <= pot;
        i_stop_delay <= sd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_word();
        int      r;
        t_action act;
        logic [DELAY_W-1:0] sd;
        r = $urandom_range(0, 99);
        if (r < 70)      act = ACT_TICK;
        else if (r < 79) act = $urandom_range(0, 1) ? ACT_FWD : ACT_BACK;
        else if (r < 86) act = $urandom_range(0, 1) ? ACT_LEFT : ACT_RIGHT;
        else if (r < 91) act = ACT_STOP;
        else if (r < 97) act = ACT_ARM;
        else             act = ACT_CANCEL;
        r = $urandom_range(0, 19);
        if (r == 0)      sd = '0;
        else if (r < 3)  sd = $urandom();
        else             sd = $urandom_range(1, 24);
        send_word(act, 10'($urandom_range(0, 1023)), sd);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_profile(input logic [7:0] turn, input logic [7:0] fwd,
                                 input logic [6:0] astep, input logic [7:0] sstep,
                                 input logic [15:0] adly, input logic [15:0] sdly,
                                 input logic [7:0] dv, input logic [7:0] lim);
        write_reg(CFG_TURN_ANGLE, {8'h00, turn});
        write_reg(CFG_FORWARD_ANGLE, {8'h00, fwd});
        write_reg(CFG_ANGLE_STEP, {9'h000, astep});
        write_reg(CFG_SPEED_STEP, {8'h00, sstep});
        write_reg(CFG_ANGLE_DLY, adly);
        write_reg(CFG_SPEED_DLY, sdly);
        write_reg(CFG_ROT_DIV, {8'h00, dv});
        write_reg(CFG_SPEED_LIMIT, {8'h00, lim});
    endtask

    task automatic load_profile(input int p);
        int ta, fa;
        ta = int'($urandom_range(0, 180)) - 90;
        fa = int'($urandom_range(0, 180)) - 90;
        case (p)
            // targets beyond the angle limit, nothing ever applied to the wheels
            2: write_profile(8'h80, 8'h7F, 7'h7F, 8'hFF, 16'h0000, 16'h0000, 8'h00, 8'h00);
            // unit steps, maximum waits: only new commands move things on
            5: write_profile(8'hA6, 8'h5A, 7'h00, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
            8: write_profile(TURN_ANGLE_RST, FORWARD_ANGLE_RST, ANGLE_STEP_RST,
                             SPEED_STEP_RST, ANGLE_DLY_RST, SPEED_DLY_RST,
                             ROT_DIV_RST, SPEED_LIMIT_RST);
            default: write_profile(ta[7:0], fa[7:0], 7'($urandom_range(15, 90)),
                                   8'($urandom_range(20, 255)), 16'($urandom_range(0, 2)),
                                   16'($urandom_range(0, 2)), 8'($urandom_range(1, 6)),
                                   ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(100, 255)));
        endcase
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_action      = ACT_TICK;
        i_pot_value   = '0;
        i_stop_delay  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_TURN_ANGLE;
        i_cfg_data    = '0;
        idle_mode     = 0;
        send_idle_pct = 28;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fast ramps, then every action and the stop-delay extremes
        write_profile(8'd45, 8'hF6, 7'd30, 8'd100, 16'd0, 16'd0, 8'd3, 8'd255);
        send_word(ACT_FWD, 10'd1023, 32'd1);
        repeat (5) send_word(ACT_TICK, 10'd0, 32'd1);
        send_word(ACT_BACK, 10'd1, 32'd1);           // refused while moving
        repeat (2) send_word(ACT_TICK, 10'd0, 32'd1);
        send_word(ACT_STOP, 10'd0, 32'd1);
        repeat (4) send_word(ACT_TICK, 10'd0, 32'd1);
        send_word(ACT_LEFT, 10'd777, 32'd1);
        repeat (3) send_word(ACT_TICK, 10'd0, 32'd1);
        send_word(ACT_ARM, 10'd0, 32'd3);
        repeat (3) send_word(ACT_TICK, 10'd0, 32'd1);
        send_word(ACT_RIGHT, 10'd0, 32'd1);
        send_word(ACT_ARM, 10'd0, 32'd0);            // zero delay cancels
        send_word(ACT_CANCEL, 10'd512, 32'd7);
        send_word(ACT_ARM, 10'd1023, 32'hFFFF_FFFF);

        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            hold_until_drained();
            idle_mode = (p <= 3) ? 0 : (p <= 7) ? 1 : 2;
            send_idle_pct = (idle_mode == 0) ? 28 : (idle_mode == 1) ? 47 : 0;
            load_profile(p);
            repeat (WORDS_PER_PHASE) random_word();
        end

        hold_until_drained();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
